@@ hdl/fixed_frame_sync_sum8_unit_assert.svh @@
// Assertion macros used by the checker file ffss_checker.sv.
`ifndef FIXED_FRAME_SYNC_SUM8_UNIT_ASSERT_SVH
`define FIXED_FRAME_SYNC_SUM8_UNIT_ASSERT_SVH

// Clocked assertion, muted while reset is high.
`define FFSS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define FFSS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ hdl/ffss_pkg.sv @@
package ffss_pkg;

  localparam int FRAME_BYTES = 11;
  localparam int SUM_BYTES   = FRAME_BYTES - 1;
  localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam logic [7:0] HEADER_BYTE = 8'h55;

  typedef logic [7:0]        byte_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef byte_t             win_t [FRAME_BYTES];

  typedef struct packed {
    logic [31:0] bad_total;
    logic [31:0] good_total;
    logic [15:0] word3;
    logic [15:0] word2;
    logic [15:0] word1;
    logic [15:0] word0;
    byte_t       frame_type;
  } frame_t;

endpackage

@@ hdl/ffss_core.sv @@
module ffss_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  ffss_pkg::byte_t rx_byte,
  output logic            hit,
  output ffss_pkg::frame_t res
);
  import ffss_pkg::*;

  win_t        window;
  win_t        window_next;
  win_t        wa;
  fill_t       fill_level;
  fill_t       fill_next;
  fill_t       fa;
  fill_t       shift_k;
  fill_t       src;
  logic        found;
  logic        full;
  byte_t       sum;
  logic [31:0] good_count;
  logic [31:0] bad_count;

  always_comb begin
    // append the new byte; an empty window takes only a header
    wa = window;
    if (fill_level < fill_t'(FRAME_BYTES)) begin
      wa[fill_level[FILL_W-1:0]] = rx_byte;
    end
    if (fill_level == '0 && rx_byte != HEADER_BYTE) begin
      fa = '0;
    end else begin
      fa = fill_level + fill_t'(1);
    end
    full = (fa == fill_t'(FRAME_BYTES));

    // checksum over the first ten bytes
    sum = '0;
    for (int i = 0; i < SUM_BYTES; i++) begin
      sum = sum + wa[i];
    end
    hit = full && (sum == wa[FRAME_BYTES-1]);

    // next header after the first byte, for resync
    found   = 1'b0;
    shift_k = '0;
    src     = '0;
    for (int j = FRAME_BYTES - 1; j >= 1; j--) begin
      if (wa[j] == HEADER_BYTE) begin
        found   = 1'b1;
        shift_k = fill_t'(j);
      end
    end

    window_next = wa;
    fill_next   = fa;
    if (full) begin
      if (hit) begin
        fill_next = '0;
      end else if (found) begin
        fill_next = fill_t'(FRAME_BYTES) - shift_k;
        for (int i = 0; i < FRAME_BYTES; i++) begin
          src = fill_t'(i) + shift_k;
          if (src < fill_t'(FRAME_BYTES)) begin
            window_next[i] = wa[src];
          end
        end
      end else begin
        fill_next = '0;
      end
    end

    // result fields
    res.frame_type = wa[1];
    res.word0      = {wa[3], wa[2]};
    res.word1      = {wa[5], wa[4]};
    res.word2      = {wa[7], wa[6]};
    res.word3      = {wa[9], wa[8]};
    res.good_total = good_count + 32'd1;
    res.bad_total  = bad_count;
  end

  // hold window and counters until a byte is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level <= '0;
      good_count <= '0;
      bad_count  <= '0;
    end else if (step) begin
      fill_level <= fill_next;
      if (full && hit) begin
        good_count <= good_count + 32'd1;
      end
      if (full && !hit) begin
        bad_count <= bad_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      window <= window_next;
    end
  end

endmodule

@@ hdl/fixed_frame_sync_sum8_unit.sv @@
// Channel  Dir  Width  Contents
// s_axis   in   8      rx_byte
// m_axis   out  136    frame_type, word0..word3, good_total, bad_total
//
// One byte per cycle unless m_tready stalls. A byte is captured in the input
// register, then the append, header search and ten-byte sum run in one pass
// into the result register, which raises m_tvalid for a good frame's last byte.
// Reset clears the fill level, both counters and all valid flags.
// A result stalled on m_tready stalls the whole pipe, and s_tready drops.
module fixed_frame_sync_sum8_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata    // [7:0] frame_type, [23:8] word0, [39:24] word1,
                                  // [55:40] word2, [71:56] word3,
                                  // [103:72] good_total, [135:104] bad_total
);
  import ffss_pkg::*;

  logic   advance;
  logic   byte_vld;
  byte_t  byte_q;
  logic   hit;
  frame_t res;
  frame_t out_q;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  ffss_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance && byte_vld),
    .rx_byte (byte_q),
    .hit     (hit),
    .res     (res)
  );

  // advance input and result registers together
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      byte_vld <= s_tvalid;
      m_tvalid <= byte_vld && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_q <= s_tdata;
      out_q  <= res;
    end
  end

  assign m_tdata = {out_q.bad_total, out_q.good_total, out_q.word3, out_q.word2,
                    out_q.word1, out_q.word0, out_q.frame_type};

endmodule

@@ hdl/ffss_checker.sv @@
`include "fixed_frame_sync_sum8_unit_assert.svh"

module ffss_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata
);

  logic        seen;
  logic [31:0] last_good;
  logic        out_beat;

  assign out_beat = m_tvalid && m_tready;

  // remember the good count of the last delivered frame
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_beat) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      last_good <= m_tdata[103:72];
    end
  end

  `FFSS_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
  `FFSS_ASSERT(a_no_in_on_stall, clk, rst, m_tvalid && !m_tready |-> !s_tready, "input taken while result stalled")
  `FFSS_ASSERT(a_good_step, clk, rst, out_beat && seen |-> m_tdata[103:72] == last_good + 32'd1, "good count skipped")
  `FFSS_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind fixed_frame_sync_sum8_unit ffss_checker u_ffss_checker (.*);

@@ tb/sv/ffss_frame_checker.sv @@
// Watches both channels of the frame synchronizer, tracks the byte window on
// its own and compares every output beat with the oldest frame still owed.
module ffss_frame_checker
  import ffss_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [135:0] m_tdata,   // [7:0] frame_type, [23:8] word0, [39:24] word1,
                                  // [55:40] word2, [71:56] word3,
                                  // [103:72] good_total, [135:104] bad_total
  output int           mismatches,
  output int           frames_owed
);

  byte_t       sync_win [FRAME_BYTES];
  int unsigned sync_fill;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;
  frame_t      owed_frames [$];

  // Shift the window left by n bytes.
  function automatic void drop_lead(int unsigned n);
    for (int unsigned i = 0; i + n < sync_fill; i++) sync_win[i] = sync_win[i + n];
    sync_fill -= n;
  endfunction

  // Drop every leading byte that is not a header.
  function automatic void seek_header();
    int unsigned k;
    k = 0;
    while (k < sync_fill && sync_win[k] != HEADER_BYTE) k++;
    drop_lead(k);
  endfunction

  // Append one byte and validate the window once it holds a whole frame.
  function automatic void take_byte(byte_t b);
    byte_t  sum;
    frame_t f;
    sync_win[sync_fill] = b;
    sync_fill++;
    seek_header();
    if (sync_fill < FRAME_BYTES) return;
    sum = '0;
    for (int k = 0; k < SUM_BYTES; k++) sum += sync_win[k];
    if (sum == sync_win[SUM_BYTES]) begin
      good_frames++;
      f.frame_type = sync_win[1];
      f.word0      = {sync_win[3], sync_win[2]};
      f.word1      = {sync_win[5], sync_win[4]};
      f.word2      = {sync_win[7], sync_win[6]};
      f.word3      = {sync_win[9], sync_win[8]};
      f.good_total = good_frames;
      f.bad_total  = bad_frames;
      owed_frames.push_back(f);
      sync_fill = 0;
    end else begin
      // bad checksum: drop the header and resync on the next one
      bad_frames++;
      drop_lead(1);
      seek_header();
    end
  endfunction

  function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    frame_t got;
    frame_t want;
    if (rst) begin
      sync_fill   = 0;
      good_frames = '0;
      bad_frames  = '0;
      owed_frames.delete();
      mismatches  = 0;
    end else begin
      // compare an output beat with the oldest owed frame
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (owed_frames.size() == 0) begin
          $display("%0t: expected no frame, actual %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = owed_frames.pop_front();
          check_field("frame_type", want.frame_type, got.frame_type);
          check_field("word0", want.word0, got.word0);
          check_field("word1", want.word1, got.word1);
          check_field("word2", want.word2, got.word2);
          check_field("word3", want.word3, got.word3);
          check_field("good_total", want.good_total, got.good_total);
          check_field("bad_total", want.bad_total, got.bad_total);
        end
      end
      // advance the window on every accepted input beat
      if (s_tvalid && s_tready) take_byte(s_tdata);
    end
    frames_owed = owed_frames.size();
  end

endmodule

@@ tb/sv/tb_fixed_frame_sync_sum8_unit.sv @@
module tb_fixed_frame_sync_sum8_unit;
  import ffss_pkg::*;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata  = '0;   // [7:0] rx_byte
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;         // [7:0] frame_type, [23:8] word0, [39:24] word1,
                                 // [55:40] word2, [71:56] word3,
                                 // [103:72] good_total, [135:104] bad_total

  int    mismatches;
  int    frames_owed;
  int    bytes_sent = 0;
  bit    gaps_on    = 1'b1;
  byte_t body [SUM_BYTES - 1];   // type byte and eight payload bytes

  fixed_frame_sync_sum8_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ffss_frame_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .frames_owed (frames_owed)
  );

  always #6 clk = ~clk;

  // Stall the output side at random unless the steady stretch is on.
  always @(posedge clk) begin
    m_tready <= !gaps_on || ($urandom_range(0, 99) >= 26);
  end

  // Offer one byte, idling first at random, and hold it until accepted.
  task automatic send_byte(input byte_t b);
    while (gaps_on && $urandom_range(0, 99) < 26) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // Send header, body and checksum; flip checksum bits when asked.
  task automatic send_frame(input bit corrupt);
    byte_t sum;
    sum = HEADER_BYTE;
    send_byte(HEADER_BYTE);
    for (int i = 0; i < SUM_BYTES - 1; i++) begin
      sum += body[i];
      send_byte(body[i]);
    end
    if (corrupt) sum ^= byte_t'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  initial begin
    #3_000_000;
    $display("fixed_frame_sync_sum8_unit: mismatch");
    $finish;
  end

  initial begin
    int pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // junk ahead of any header leaves the window empty
    send_byte(8'h00);
    send_byte(8'hFF);
    // good frame with every body byte at its maximum
    for (int i = 0; i < SUM_BYTES - 1; i++) body[i] = 8'hFF;
    send_frame(1'b0);
    // bad checksum with a header byte inside the payload to resync on
    for (int i = 0; i < SUM_BYTES - 1; i++) body[i] = 8'h00;
    body[2] = HEADER_BYTE;
    send_frame(1'b1);

    // mostly clean frames, with bad checksums, noise and cut-off frames mixed in
    while (bytes_sent < 775) begin
      gaps_on = !(bytes_sent >= 300 && bytes_sent < 450);
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        for (int i = 0; i < SUM_BYTES - 1; i++)
          body[i] = ($urandom_range(0, 7) == 0) ? HEADER_BYTE : byte_t'($urandom_range(0, 255));
        send_frame(pick >= 70);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom_range(0, 255)));
      end else begin
        send_byte(HEADER_BYTE);
        repeat ($urandom_range(1, 9)) send_byte(byte_t'($urandom_range(0, 255)));
      end
    end
    s_tvalid <= 1'b0;

    // drain owed frames, then give the pipe time to show anything extra
    do @(posedge clk); while (frames_owed != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("fixed_frame_sync_sum8_unit: match");
    end else begin
      $display("fixed_frame_sync_sum8_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ffss_pkg.sv
hdl/ffss_core.sv
hdl/fixed_frame_sync_sum8_unit.sv
hdl/ffss_checker.sv
tb/sv/ffss_frame_checker.sv
tb/sv/tb_fixed_frame_sync_sum8_unit.sv
